### rtl/y2b_pkg.sv
`default_nettype none

package y2b_pkg;

  // Frame store geometry.
  localparam int STORE_BYTES = 262144;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Port widths.
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 24;
  localparam int OUT_USER_W  = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 19;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANAR    = 3'd0,
    REG_STRIDE    = 3'd1,
    REG_ROWS      = 3'd2,
    REG_VIS_W     = 3'd3,
    REG_VIS_H     = 3'd4,
    REG_BUF_BYTES = 3'd5
  } cfg_reg_t;

  // Word kinds on the input channel.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Result status codes.
  localparam logic [OUT_USER_W-1:0] ST_OK    = 2'd0;
  localparam logic [OUT_USER_W-1:0] ST_SMALL = 2'd1;
  localparam logic [OUT_USER_W-1:0] ST_CROP  = 2'd2;

  // BT.601 coefficients, scaled by 1000 (red, blue) or 1000000 (green).
  localparam logic [10:0] COEF_RV     = 11'd1402;
  localparam logic [18:0] COEF_GU     = 19'd344136;
  localparam logic [19:0] COEF_GV     = 20'd714136;
  localparam logic [10:0] COEF_BU     = 11'd1772;
  localparam logic [7:0]  CHROMA_BIAS = 8'd128;

  // Reciprocals for exact truncating division: q = (m * REC) >> SH.
  // Each is ceil(2^SH / d) with an error small enough for the product range.
  localparam logic [18:0] REC_1K    = 19'd268436;
  localparam int          REC_1K_SH = 28;
  localparam logic [26:0] REC_GU    = 27'd70368745;
  localparam int          REC_GU_SH = 46;
  localparam logic [27:0] REC_GV    = 28'd140737489;
  localparam int          REC_GV_SH = 47;

endpackage

`default_nettype wire

### rtl/yuv420_frame_to_bgra_converter_top.sv
`default_nettype none

// YUV 4:2:0 frame store with a BT.601 pixel converter. Input words with tuser
// low write one byte into a 256 KiB single-port frame memory; words with
// tuser high request one pixel, which returns blue, green and red with a
// status in out_tuser (ok, buffer too small, outside crop). A pixel request
// that converts passes through the accepting cycle, geometry, address math,
// three memory reads of Y, U and V from the single port, the multiply, the
// reciprocal divide, and the clamp and load of the output register; one that
// a check rejects passes through acceptance, geometry, check and load. A
// stalled result word adds its stall to the request that follows it. Bytes
// are taken one per cycle while the block is idle; a pixel request holds them
// off until its result is loaded. Memory content is undefined until written;
// there is no clearing pass. Write configuration only while the block is
// idle.
module yuv420_frame_to_bgra_converter_top
  import y2b_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  // in_tdata: byte_address[17:0], byte_value[25:18], pixel_row[37:26],
  // pixel_col[49:38], zero fill above.
  input  wire  [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind.
  input  wire                   in_tuser,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // out_tdata: blue[7:0], green[15:8], red[23:16].
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status.
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_GEOM  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_RD_Y  = 9'b000001000,
    S_RD_U  = 9'b000010000,
    S_RD_V  = 9'b000100000,
    S_MUL1  = 9'b001000000,
    S_MUL2  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic        planar_r;
  logic [13:0] stride_r;
  logic [13:0] rows_r;
  logic [12:0] vis_w_r;
  logic [12:0] vis_h_r;
  logic [18:0] buf_bytes_r;

  // Request and geometry registers.
  logic [11:0]       row_r, col_r;
  logic [27:0]       ysize_r;
  logic [26:0]       chalf_r;
  logic [ADDR_W-1:0] yoff_r, crow_r;
  logic [ADDR_W-1:0] y_addr_r, u_addr_r, v_addr_r;
  logic [1:0]        status_r;

  // Memory and conversion registers.
  logic [7:0]  mem [STORE_BYTES];
  logic [7:0]  mem_q_r;
  logic [7:0]  luma_r, cb_r;
  logic        u_neg_r, v_neg_r;
  logic [17:0] prod_rv_r, prod_bu_r;
  logic [25:0] prod_gu_r;
  logic [26:0] prod_gv_r;
  logic [7:0]  q_rv_r, q_gu_r, q_gv_r, q_bu_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  // Input fields.
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_byte;
  logic [11:0]       in_row, in_col;
  logic              in_acc;

  assign in_addr = in_tdata[17:0];
  assign in_byte = in_tdata[25:18];
  assign in_row  = in_tdata[37:26];
  assign in_col  = in_tdata[49:38];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Geometry.
  logic [13:0]       c_rs;
  logic [12:0]       half_rows;
  logic [27:0]       ysize_nxt;
  logic [26:0]       chalf_nxt;
  logic [ADDR_W-1:0] yoff_nxt, crow_nxt;

  assign c_rs      = planar_r ? {1'b0, stride_r[13:1]} : stride_r;
  assign half_rows = rows_r[13:1];
  assign ysize_nxt = 28'(stride_r) * 28'(rows_r);
  assign chalf_nxt = 27'(c_rs) * 27'(half_rows);
  assign yoff_nxt  = ADDR_W'(26'(row_r) * 26'(stride_r));
  assign crow_nxt  = ADDR_W'(25'(row_r[11:1]) * 25'(c_rs));

  // Size and crop checks, byte addresses.
  logic [29:0]       last_end;
  logic              too_small, outside;
  logic [ADDR_W-1:0] ccol, y_addr_nxt, u_addr_nxt, v_addr_nxt;

  // The end of the last chroma row never lies below the end of the luma plane.
  assign last_end   = planar_r ? 30'(ysize_r) + (30'(chalf_r) << 1)
                               : 30'(ysize_r) + 30'(chalf_r) + 30'd1;
  assign too_small  = last_end > 30'(buf_bytes_r);
  assign outside    = (13'(row_r) >= vis_h_r) || (13'(col_r) >= vis_w_r);
  assign ccol       = planar_r ? ADDR_W'(col_r[11:1]) : ADDR_W'({col_r[11:1], 1'b0});
  assign y_addr_nxt = yoff_r + ADDR_W'(col_r);
  assign u_addr_nxt = ysize_r[ADDR_W-1:0] + crow_r + ccol;
  assign v_addr_nxt = planar_r ? u_addr_nxt + chalf_r[ADDR_W-1:0]
                               : u_addr_nxt + ADDR_W'(1);

  // Memory port.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;

  assign mem_we = in_acc && (in_tuser == KIND_BYTE);

  always_comb begin
    unique case (state_r)
      S_IDLE:  mem_addr = in_addr;
      S_RD_U:  mem_addr = u_addr_r;
      S_RD_V:  mem_addr = v_addr_r;
      default: mem_addr = y_addr_r;
    endcase
  end

  // Writes happen only in idle, so a read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_byte;
    end
    mem_q_r <= mem[mem_addr];
  end

  // Chroma magnitudes and signs; mem_q_r holds V during S_MUL1.
  logic       u_neg_nxt, v_neg_nxt;
  logic [7:0] u_mag, v_mag;

  assign u_neg_nxt = cb_r < CHROMA_BIAS;
  assign v_neg_nxt = mem_q_r < CHROMA_BIAS;
  assign u_mag     = u_neg_nxt ? CHROMA_BIAS - cb_r : cb_r - CHROMA_BIAS;
  assign v_mag     = v_neg_nxt ? CHROMA_BIAS - mem_q_r : mem_q_r - CHROMA_BIAS;

  logic [36:0] full_rv, full_bu;
  logic [52:0] full_gu;
  logic [54:0] full_gv;

  assign full_rv = 37'(prod_rv_r) * 37'(REC_1K);
  assign full_bu = 37'(prod_bu_r) * 37'(REC_1K);
  assign full_gu = 53'(prod_gu_r) * 53'(REC_GU);
  assign full_gv = 55'(prod_gv_r) * 55'(REC_GV);

  // Final sums and clamp.
  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic signed [10:0] luma_s, t_rv, t_gu, t_gv, t_bu, r_sum, g_sum, b_sum;

  assign luma_s = $signed(11'(luma_r));
  assign t_rv   = v_neg_r ? -$signed(11'(q_rv_r)) : $signed(11'(q_rv_r));
  assign t_gu   = u_neg_r ? -$signed(11'(q_gu_r)) : $signed(11'(q_gu_r));
  assign t_gv   = v_neg_r ? -$signed(11'(q_gv_r)) : $signed(11'(q_gv_r));
  assign t_bu   = u_neg_r ? -$signed(11'(q_bu_r)) : $signed(11'(q_bu_r));
  assign r_sum  = luma_s + t_rv;
  assign g_sum  = luma_s - t_gu - t_gv;
  assign b_sum  = luma_s + t_bu;

  logic out_load;
  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == KIND_PIXEL)) begin
          state_nxt = S_GEOM;
        end
      end
      S_GEOM:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = (too_small || outside) ? S_DONE : S_RD_Y;
      S_RD_Y:  state_nxt = S_RD_U;
      S_RD_U:  state_nxt = S_RD_V;
      S_RD_V:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      planar_r     <= 1'b0;
      stride_r     <= '0;
      rows_r       <= '0;
      vis_w_r      <= '0;
      vis_h_r      <= '0;
      buf_bytes_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_PLANAR:    planar_r    <= cfg_data[0];
          REG_STRIDE:    stride_r    <= cfg_data[13:0];
          REG_ROWS:      rows_r      <= cfg_data[13:0];
          REG_VIS_W:     vis_w_r     <= cfg_data[12:0];
          REG_VIS_H:     vis_h_r     <= cfg_data[12:0];
          REG_BUF_BYTES: buf_bytes_r <= cfg_data;
          default:       ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (state_r == S_GEOM) begin
      ysize_r <= ysize_nxt;
      chalf_r <= chalf_nxt;
      yoff_r  <= yoff_nxt;
      crow_r  <= crow_nxt;
    end
    if (state_r == S_CHECK) begin
      y_addr_r <= y_addr_nxt;
      u_addr_r <= u_addr_nxt;
      v_addr_r <= v_addr_nxt;
      if (too_small) begin
        status_r <= ST_SMALL;
      end else if (outside) begin
        status_r <= ST_CROP;
      end else begin
        status_r <= ST_OK;
      end
    end
    if (state_r == S_RD_U) begin
      luma_r <= mem_q_r;
    end
    if (state_r == S_RD_V) begin
      cb_r <= mem_q_r;
    end
    if (state_r == S_MUL1) begin
      u_neg_r   <= u_neg_nxt;
      v_neg_r   <= v_neg_nxt;
      prod_rv_r <= 18'(COEF_RV) * 18'(v_mag);
      prod_bu_r <= 18'(COEF_BU) * 18'(u_mag);
      prod_gu_r <= 26'(COEF_GU) * 26'(u_mag);
      prod_gv_r <= 27'(COEF_GV) * 27'(v_mag);
    end
    if (state_r == S_MUL2) begin
      q_rv_r <= full_rv[REC_1K_SH +: 8];
      q_bu_r <= full_bu[REC_1K_SH +: 8];
      q_gu_r <= 8'(full_gu[REC_GU_SH +: 7]);
      q_gv_r <= full_gv[REC_GV_SH +: 8];
    end
    if (out_load) begin
      out_tuser_r <= status_r;
      if (status_r == ST_OK) begin
        out_tdata_r <= {clamp8(r_sum), clamp8(g_sum), clamp8(b_sum)};
      end else begin
        out_tdata_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

### rtl/y2b_checker.sv
`default_nettype none

module y2b_checker
  import y2b_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_tvalid,
  input wire                  in_tready,
  input wire                  in_tuser,
  input wire                  out_tvalid,
  input wire                  out_tready,
  input wire [OUT_DATA_W-1:0] out_tdata,
  input wire [OUT_USER_W-1:0] out_tuser
);

  // A result word that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Only the three defined status codes ever appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_SMALL) || (out_tuser == ST_CROP))
    else $error("undefined status code");

  // A rejected request carries black.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("rejected request carries color data");

  // A pixel request keeps the input closed on the following cycle.
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready && (in_tuser == KIND_PIXEL) |=> !in_tready)
    else $error("input open right after a pixel request");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind yuv420_frame_to_bgra_converter_top y2b_checker u_y2b_checker (.*);

`default_nettype wire

### tb/bgr_checker.sv
`timescale 1ns / 1ps

module bgr_checker
  import y2b_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [IN_DATA_W-1:0]  in_tdata,
  input  wire                   in_tuser,
  input  wire                   in_tvalid,
  input  wire                   in_tready,
  input  wire  [OUT_DATA_W-1:0] out_tdata,
  input  wire  [OUT_USER_W-1:0] out_tuser,
  input  wire                   out_tvalid,
  input  wire                   out_tready,
  input  wire                   cfg_valid,
  input  wire                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam int MUL_RV = 1402;
  localparam int MUL_GU = 344136;
  localparam int MUL_GV = 714136;
  localparam int MUL_BU = 1772;
  localparam int DIV_RB = 1000;
  localparam int DIV_G  = 1000000;

  logic [7:0]  frame_copy [STORE_BYTES];
  bit          is_planar;
  logic [13:0] stride;
  logic [13:0] rows;
  logic [12:0] vis_w;
  logic [12:0] vis_h;
  logic [18:0] buf_bytes;

  pixel_t      due_pixels [$];
  int unsigned fails;
  int unsigned results_seen;

  assign mismatches = fails;

  // Bytes a layout occupies: the luma plane, or the end of the last chroma row
  // if that lies further out.
  function automatic longint unsigned frame_need(input bit planar,
                                                 input longint unsigned stride_b,
                                                 input longint unsigned rows_b);
    longint unsigned luma, chroma_row, v_start, tail;
    luma       = stride_b * rows_b;
    chroma_row = planar ? stride_b / 2 : stride_b;
    v_start    = planar ? luma + chroma_row * (rows_b / 2) : luma + 1;
    tail       = v_start + chroma_row * (rows_b / 2);
    return (luma > tail) ? luma : tail;
  endfunction

  // Status of a pixel request under the current geometry, and the three byte
  // addresses it reads when it converts.
  function automatic logic [1:0] locate(input logic [11:0] row, input logic [11:0] col,
                                        output logic [ADDR_W-1:0] y_at,
                                        output logic [ADDR_W-1:0] u_at,
                                        output logic [ADDR_W-1:0] v_at);
    longint unsigned luma, chroma_row, step, v_start, chroma_off;
    luma       = stride * rows;
    chroma_row = is_planar ? stride / 2 : stride;
    step       = is_planar ? 1 : 2;
    v_start    = is_planar ? luma + chroma_row * (rows / 2) : luma + 1;
    y_at = '0;
    u_at = '0;
    v_at = '0;
    if (frame_need(is_planar, stride, rows) > buf_bytes) return ST_SMALL;
    if (row >= vis_h || col >= vis_w) return ST_CROP;
    chroma_off = (row / 2) * chroma_row + (col / 2) * step;
    y_at = ADDR_W'((longint'(row) * stride + col) % STORE_BYTES);
    u_at = ADDR_W'((luma + chroma_off) % STORE_BYTES);
    v_at = ADDR_W'((v_start + chroma_off) % STORE_BYTES);
    return ST_OK;
  endfunction

  function automatic logic [7:0] sat8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic pixel_t convert_pixel(input logic [11:0] row, input logic [11:0] col);
    pixel_t            px;
    logic [ADDR_W-1:0] ya, ua, va;
    int                luma_v, cb, cr;
    px = '0;
    px.status = locate(row, col, ya, ua, va);
    if (px.status == ST_OK) begin
      luma_v = int'(frame_copy[ya]);
      cb     = int'(frame_copy[ua]) - 128;
      cr     = int'(frame_copy[va]) - 128;
      // Signed integer division truncates toward zero, as the conversion needs.
      px.red   = sat8(luma_v + (MUL_RV * cr) / DIV_RB);
      px.green = sat8(luma_v - (MUL_GU * cb) / DIV_G - (MUL_GV * cr) / DIV_G);
      px.blue  = sat8(luma_v + (MUL_BU * cb) / DIV_RB);
    end
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      is_planar = 1'b0;
      stride    = '0;
      rows      = '0;
      vis_w     = '0;
      vis_h     = '0;
      buf_bytes = '0;
      due_pixels.delete();
      fails        = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PLANAR:    is_planar = cfg_data[0];
          REG_STRIDE:    stride    = cfg_data[13:0];
          REG_ROWS:      rows      = cfg_data[13:0];
          REG_VIS_W:     vis_w     = cfg_data[12:0];
          REG_VIS_H:     vis_h     = cfg_data[12:0];
          REG_BUF_BYTES: buf_bytes = cfg_data[18:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_BYTE) begin
          frame_copy[in_tdata[17:0]] = in_tdata[25:18];
        end else begin
          due_pixels.push_back(convert_pixel(in_tdata[37:26], in_tdata[49:38]));
        end
      end
      if (out_tvalid && out_tready) begin
        got.blue   = out_tdata[7:0];
        got.green  = out_tdata[15:8];
        got.red    = out_tdata[23:16];
        got.status = out_tuser;
        if (due_pixels.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: unexpected result word %0d: b=%0d g=%0d r=%0d st=%0d", $realtime,
                     results_seen, got.blue, got.green, got.red, got.status);
          end
          fails++;
        end else begin
          want = due_pixels.pop_front();
          if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
              got.status !== want.status) begin
            if (fails < 10) begin
              $display("%0t: result word %0d: expected b=%0d g=%0d r=%0d st=%0d, got b=%0d g=%0d r=%0d st=%0d",
                       $realtime, results_seen, want.blue, want.green, want.red, want.status,
                       got.blue, got.green, got.red, got.status);
            end
            fails++;
          end
        end
        results_seen++;
      end
    end
    pending <= due_pixels.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import y2b_pkg::*;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = KIND_BYTE;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned pending;

  // Stimulus-side record of which store bytes hold data, so that no request
  // ever reads a byte that was never written.
  bit          loaded [STORE_BYTES];
  int unsigned words_sent;
  bit          gaps_on = 1'b1;
  bit          ready_free = 1'b0;
  int unsigned stall_left;
  int unsigned stall_roll;

  yuv420_frame_to_bgra_converter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bgr_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: mostly short stalls, now and then a long one, and whole
  // phases with no stall at all.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (ready_free) begin
      out_tready <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_tready <= 1'b1;
      end else if (stall_roll < 94) begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(10, 60);
      end
    end
  end

  task automatic maybe_gap();
    int unsigned roll, len;
    len = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 93) len = $urandom_range(8, 40);
      else if (roll >= 65) len = $urandom_range(1, 3);
    end
    if (len != 0) begin
      in_tvalid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic push_word(input logic kind, input logic [IN_DATA_W-1:0] data);
    maybe_gap();
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // The fields a word does not use carry random bits.
  task automatic put_byte(input logic [ADDR_W-1:0] addr, input logic [7:0] val);
    logic [23:0] junk;
    junk = 24'($urandom);
    loaded[addr] = 1'b1;
    push_word(KIND_BYTE, {6'd0, junk[23:12], junk[11:0], val, addr});
  endtask

  task automatic ask_pixel(input logic [11:0] row, input logic [11:0] col);
    logic [ADDR_W-1:0] at [3];
    logic [1:0]        verdict;
    logic [25:0]       junk;
    verdict = chk.locate(row, col, at[0], at[1], at[2]);
    if (verdict == ST_OK) begin
      for (int i = 0; i < 3; i++) begin
        if (!loaded[at[i]]) put_byte(at[i], 8'($urandom));
      end
    end
    junk = 26'($urandom);
    push_word(KIND_PIXEL, {6'd0, col, row, junk[25:18], junk[17:0]});
  endtask

  task automatic set_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // The trailing cycle lets the checker take the new geometry before the
  // stimulus asks it for addresses.
  task automatic program_frame(input bit planar, input int unsigned stride_v,
                               input int unsigned rows_v, input int unsigned w_v,
                               input int unsigned h_v, input int unsigned buf_v);
    set_reg(REG_PLANAR, 32'(planar));
    set_reg(REG_STRIDE, stride_v);
    set_reg(REG_ROWS, rows_v);
    set_reg(REG_VIS_W, w_v);
    set_reg(REG_VIS_H, h_v);
    set_reg(REG_BUF_BYTES, buf_v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every pixel has come back, then lets a byte write that may
  // still be in flight finish before the registers change.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic int unsigned pick_edge(input int unsigned top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic run_phase();
    int unsigned     shape, stride_v, rows_v, w_v, h_v, buf_v, count, roll;
    bit              planar;
    longint unsigned need, wanted;
    logic [11:0]     row, col;
    drain();
    shape  = $urandom_range(0, 99);
    planar = 1'($urandom_range(0, 1));
    if (shape < 70) begin
      stride_v = $urandom_range(1, 12);
      rows_v   = $urandom_range(1, 8);
      w_v = ($urandom_range(0, 4) != 0) ? $urandom_range(1, stride_v)
                                        : $urandom_range(0, 3 * stride_v + 4);
      h_v = ($urandom_range(0, 4) != 0) ? $urandom_range(1, rows_v)
                                        : $urandom_range(0, 3 * rows_v + 4);
    end else if (shape < 85) begin
      stride_v = pick_edge(8192);
      rows_v   = pick_edge(8192);
      w_v      = pick_edge(4096);
      h_v      = pick_edge(4096);
    end else begin
      // Tall crops over a wide stride push the luma address past the store.
      stride_v = $urandom_range(2048, 8192);
      rows_v   = $urandom_range(1, 4);
      w_v      = 4096;
      h_v      = 4096;
    end
    need = chk.frame_need(planar, stride_v, rows_v);
    roll = $urandom_range(0, 99);
    if (roll < 75) wanted = need + $urandom_range(0, 3);
    else if (roll < 88) wanted = (need == 0) ? 0 : need - 1;
    else if (roll < 94) wanted = 262144;
    else wanted = $urandom_range(0, 262144);
    buf_v = 32'((wanted > 262144) ? 262144 : wanted);
    gaps_on    = ($urandom_range(0, 3) != 0);
    ready_free = ($urandom_range(0, 3) == 0);
    program_frame(planar, stride_v, rows_v, w_v, h_v, buf_v);

    // Sometimes load the whole frame first, as a decoder would.
    if (need <= 96 && $urandom_range(0, 2) == 0) begin
      for (int a = 0; a < need; a++) put_byte(ADDR_W'(a), 8'($urandom));
    end
    count = $urandom_range(15, 40);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        put_byte(ADDR_W'($urandom), 8'($urandom));
      end else begin
        row = (h_v != 0 && $urandom_range(0, 6) != 0) ? 12'($urandom_range(0, h_v - 1))
                                                      : 12'($urandom_range(0, 4095));
        col = (w_v != 0 && $urandom_range(0, 6) != 0) ? 12'($urandom_range(0, w_v - 1))
                                                      : 12'($urandom_range(0, 4095));
        ask_pixel(row, col);
      end
    end
  endtask

  initial begin
    int unsigned k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry needs one byte more than the empty buffer holds.
    ask_pixel(12'hFFF, 12'hFFF);
    put_byte(18'h3FFFF, 8'hFF);
    drain();

    // Tiny NV12 frame, chroma at both extremes so every channel clamps.
    program_frame(1'b0, 2, 2, 2, 2, 7);
    put_byte(0, 8'hFF);
    put_byte(1, 8'h00);
    put_byte(4, 8'hFF);
    put_byte(5, 8'hFF);
    ask_pixel(0, 0);
    ask_pixel(0, 1);
    put_byte(4, 8'h00);
    put_byte(5, 8'h00);
    ask_pixel(0, 0);
    ask_pixel(0, 1);
    ask_pixel(1, 1);
    ask_pixel(2, 0);
    ask_pixel(0, 2);
    ask_pixel(12'hFFF, 0);
    drain();

    // One byte short of the same layout.
    program_frame(1'b0, 2, 2, 2, 2, 6);
    ask_pixel(0, 0);
    drain();

    // Small I420 frame, sized exactly.
    program_frame(1'b1, 4, 2, 4, 2, 12);
    ask_pixel(0, 0);
    ask_pixel(1, 3);

    while (words_sent < 1700) run_phase();

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (k = 0; k < 20000 && pending != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
